// File: src/llsp_pkg.sv
// Package for least-loaded server placement.
// Shared types and codes; no dependencies.
package llsp_pkg;
    localparam int OP_W = 2;
    localparam int SRV_W = 4;
    localparam int CAP_W = 32;
    localparam int CNT_W = 6;
    localparam int BSZ_W = 32;
    localparam int ST_W = 2;

    localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_PRIM   = 2'd2;
    localparam logic [OP_W-1:0] OP_SEC    = 2'd3;

    localparam logic [ST_W-1:0] ST_PLACE = 2'd0;
    localparam logic [ST_W-1:0] ST_ACK   = 2'd1;
    localparam logic [ST_W-1:0] ST_NONE  = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD   = 2'd3;

    localparam logic [CAP_W-1:0] MIN_FREE_RESET = 32'd100;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SRV_W-1:0] server;
        logic             online;
        logic [CAP_W-1:0] capacity_mb;
        logic [CNT_W-1:0] request_count;
        logic [BSZ_W-1:0] block_size;
    } t_req;

    typedef struct packed {
        logic [SRV_W-1:0] chosen_server;
        logic [ST_W-1:0]  status;
        logic             last;
    } t_res;
endpackage

// File: src/llsp_if.sv
// Valid/ready channel interfaces for the placement block.
// Depends on llsp_pkg.
interface llsp_req_if;
    logic valid;
    logic ready;
    llsp_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface llsp_res_if;
    logic valid;
    logic ready;
    llsp_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/llsp_cmp.sv
// Shared 64-bit compare unit used by the sort and eligibility scan.
// Depends on nothing.
module llsp_cmp (
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_gt
);
    assign o_gt = i_a > i_b;
endmodule

// File: src/least_loaded_server_placement.sv
// Least-loaded server placement, top level.
// Ops 0/1 present their single word in the cycle after accept; ops 2/3 scan all
// N servers, sort the n eligible ones through the shared comparator, then give
// one result word per placement, each held until the receiver takes it.
// One request at a time: a new request is taken only once the last word is out.
// Reset (i_rst_n low, synchronous): tables zero, threshold 100, idle.
module least_loaded_server_placement #(
    parameter int MAX_SERVERS = 16,
    parameter int MAX_REQUEST = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    llsp_req_if.sink    i_req,
    llsp_res_if.source  o_res
);
    localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int NW = $clog2(MAX_SERVERS + 2);

    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_SORT = 3'd2,
                           S_DEAL = 3'd3, S_OUT = 3'd4, S_PRIM = 3'd5;

    logic [2:0] r_state;
    logic [31:0] r_min;
    logic [MAX_SERVERS-1:0] r_onl, r_pres;
    logic [31:0] r_cap [MAX_SERVERS];
    logic [31:0] r_pl  [MAX_SERVERS];
    logic [63:0] r_dl  [MAX_SERVERS];
    // for op 3 the primary is excluded from the scan and appended after the sort, so the list never exceeds N entries
    logic [IW-1:0] r_list [MAX_SERVERS];
    llsp_pkg::t_req r_req;
    logic [NW-1:0] r_n, r_i, r_j, r_pos;
    logic [6:0] r_left;
    logic r_ov;
    llsp_pkg::t_res r_res;

    logic [IW-1:0] a_id, b_id, scan_id, deal_id;
    logic [63:0] cmp_a, cmp_b;
    logic gt, disk;
    logic [6:0] cnt;

    assign disk = (r_req.op == llsp_pkg::OP_SEC);
    assign a_id = r_list[r_i[IW-1:0]];
    assign b_id = r_list[r_j[IW-1:0]];
    assign scan_id = r_i[IW-1:0];
    assign deal_id = r_list[r_pos[IW-1:0]];

    always_comb begin
        if (r_state == S_SCAN) begin
            cmp_a = {32'd0, r_cap[scan_id]};
            cmp_b = {32'd0, r_min};
        end else if (disk) begin
            cmp_a = r_dl[a_id];
            cmp_b = r_dl[b_id];
        end else begin
            cmp_a = {32'd0, r_pl[a_id]};
            cmp_b = {32'd0, r_pl[b_id]};
        end
    end

    llsp_cmp u_cmp (.i_a(cmp_a), .i_b(cmp_b), .o_gt(gt));

    always_comb begin
        cnt = {1'b0, i_req.data.request_count};
        if (cnt > 7'(MAX_REQUEST)) cnt = 7'(MAX_REQUEST);
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res.valid = (r_state == S_OUT) || (r_state == S_PRIM);
    assign o_res.data = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_min <= llsp_pkg::MIN_FREE_RESET;
            r_onl <= '0;
            r_pres <= '0;
            for (int k = 0; k < MAX_SERVERS; k++) begin
                r_cap[k] <= '0;
                r_pl[k] <= '0;
                r_dl[k] <= '0;
            end
        end else begin
            if (i_cfg_we) r_min <= i_cfg_data;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req <= i_req.data;
                        r_left <= cnt;
                        r_i <= '0;
                        r_n <= '0;
                        r_pos <= '0;
                        r_ov <= 1'b0;
                        r_state <= S_OUT;
                        r_res <= '{chosen_server: i_req.data.server,
                                   status: llsp_pkg::ST_ACK, last: 1'b1};
                        if (32'(i_req.data.server) >= 32'(MAX_SERVERS)) begin
                            r_res <= '{chosen_server: '0, status: llsp_pkg::ST_BAD,
                                       last: 1'b1};
                        end else if (i_req.data.op == llsp_pkg::OP_UPDATE) begin
                            r_onl[i_req.data.server[IW-1:0]] <= i_req.data.online;
                            r_cap[i_req.data.server[IW-1:0]] <= i_req.data.capacity_mb;
                        end else if (i_req.data.op == llsp_pkg::OP_ADD) begin
                            if (!r_pres[i_req.data.server[IW-1:0]]) begin
                                r_pres[i_req.data.server[IW-1:0]] <= 1'b1;
                                r_pl[i_req.data.server[IW-1:0]] <= '0;
                                r_dl[i_req.data.server[IW-1:0]] <= '0;
                            end
                        end else if (cnt == 7'd0) begin
                            r_res <= '{chosen_server: '0, status: llsp_pkg::ST_BAD,
                                       last: 1'b1};
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_onl[scan_id] && gt &&
                        !(disk && scan_id == r_req.server[IW-1:0])) begin
                        r_list[r_n[IW-1:0]] <= scan_id;
                        r_n <= r_n + 1'b1;
                    end
                    if (r_i == NW'(MAX_SERVERS - 1)) begin
                        r_i <= '0;
                        r_j <= NW'(1);
                        r_state <= S_SORT;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_SORT: begin
                    if (r_n >= NW'(2)) r_pres[a_id] <= 1'b1;
                    if (r_j < r_n) begin
                        if (gt) begin
                            r_list[r_i[IW-1:0]] <= b_id;
                            r_list[r_j[IW-1:0]] <= a_id;
                        end
                        r_j <= r_j + 1'b1;
                    end else if (r_i + 1'b1 < r_n) begin
                        r_i <= r_i + 1'b1;
                        r_j <= r_i + NW'(2);
                    end else if (disk) begin
                        r_list[r_n[IW-1:0]] <= r_req.server[IW-1:0];
                        r_n <= r_n + 1'b1;
                        r_res <= '{chosen_server: r_req.server, status: llsp_pkg::ST_PLACE,
                                   last: (r_left == 7'd1)};
                        r_left <= r_left - 1'b1;
                        r_state <= S_PRIM;
                    end else if (r_n == '0) begin
                        r_res <= '{chosen_server: '0, status: llsp_pkg::ST_NONE,
                                   last: 1'b1};
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DEAL;
                    end
                end
                S_PRIM: begin
                    if (o_res.ready) r_state <= (r_left == 7'd0) ? S_IDLE : S_DEAL;
                end
                S_DEAL: begin
                    r_pres[deal_id] <= 1'b1;
                    if (disk) r_dl[deal_id] <= r_dl[deal_id] + {32'd0, r_req.block_size};
                    else r_pl[deal_id] <= r_pl[deal_id] + 32'd1;
                    r_res <= '{chosen_server: llsp_pkg::SRV_W'(deal_id),
                               status: llsp_pkg::ST_PLACE, last: (r_left == 7'd1)};
                    r_left <= r_left - 1'b1;
                    r_pos <= (r_pos + 1'b1 == r_n) ? '0 : r_pos + 1'b1;
                    r_ov <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_res.ready)
                        r_state <= (r_ov && r_left != 7'd0) ? S_DEAL : S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready)
        else $error("ready while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> $stable(o_res.data))
        else $error("result changed while stalled");
    a_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEAL) |-> (r_n != '0 && r_pos < r_n))
        else $error("deal outside list");
endmodule

// File: dv/llsp_checker.sv
`timescale 1ns / 1ps
// Placement checker: watches request and result channels, predicts results.
// Depends on llsp_pkg and llsp_if.
module llsp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    llsp_req_if         i_req,
    llsp_res_if         o_res,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int NSRV = 16;
    localparam int MAXREQ = 32;

    logic [31:0]    thresh;
    logic           on_tbl [NSRV];
    logic [31:0]    cap_tbl [NSRV];
    logic           present_tbl [NSRV];
    logic [31:0]    prim_tbl [NSRV];
    logic [63:0]    disk_tbl [NSRV];
    llsp_pkg::t_res placements_due [$];
    int             fails;
    int             due;

    assign o_fail_count = fails;
    assign o_pending = due;

    function automatic logic is_eligible(int id);
        return on_tbl[id] && cap_tbl[id] > thresh;
    endfunction

    function automatic llsp_pkg::t_res mk(logic [3:0] s, logic [1:0] st, logic l);
        llsp_pkg::t_res r;
        r.chosen_server = s;
        r.status = st;
        r.last = l;
        return r;
    endfunction

    task automatic expect_word(llsp_pkg::t_res r);
        placements_due = {placements_due, r};
    endtask

    task automatic order_by_load(ref int lst[$], input logic by_disk);
        int a;
        int b;
        logic gt;
        if (lst.size() >= 2)
            foreach (lst[i]) present_tbl[lst[i]] = 1'b1;
        for (int i = 0; i < lst.size(); i++) begin
            for (int j = i + 1; j < lst.size(); j++) begin
                a = lst[i];
                b = lst[j];
                gt = by_disk ? (disk_tbl[a] > disk_tbl[b]) : (prim_tbl[a] > prim_tbl[b]);
                if (gt) begin
                    lst[i] = b;
                    lst[j] = a;
                end
            end
        end
    endtask

    task automatic predict_placement(llsp_pkg::t_req q);
        int cands[$];
        int cnt;
        int pos;
        int id;
        cnt = q.request_count > MAXREQ ? MAXREQ : int'(q.request_count);
        if (q.op == llsp_pkg::OP_UPDATE) begin
            on_tbl[q.server] = q.online;
            cap_tbl[q.server] = q.capacity_mb;
            expect_word(mk(q.server, llsp_pkg::ST_ACK, 1'b1));
        end else if (q.op == llsp_pkg::OP_ADD) begin
            if (!present_tbl[q.server]) begin
                present_tbl[q.server] = 1'b1;
                prim_tbl[q.server] = '0;
                disk_tbl[q.server] = '0;
            end
            expect_word(mk(q.server, llsp_pkg::ST_ACK, 1'b1));
        end else if (cnt == 0) begin
            expect_word(mk(4'd0, llsp_pkg::ST_BAD, 1'b1));
        end else if (q.op == llsp_pkg::OP_PRIM) begin
            for (int i = 0; i < NSRV; i++)
                if (is_eligible(i)) cands = {cands, i};
            if (cands.size() == 0) begin
                expect_word(mk(4'd0, llsp_pkg::ST_NONE, 1'b1));
            end else begin
                order_by_load(cands, 1'b0);
                pos = 0;
                for (int i = 0; i < cnt; i++) begin
                    id = cands[pos];
                    present_tbl[id] = 1'b1;
                    prim_tbl[id] = prim_tbl[id] + 32'd1;
                    expect_word(mk(id[3:0], llsp_pkg::ST_PLACE, i + 1 == cnt));
                    pos = (pos + 1 == cands.size()) ? 0 : pos + 1;
                end
            end
        end else begin
            expect_word(mk(q.server, llsp_pkg::ST_PLACE, cnt == 1));
            for (int i = 0; i < NSRV; i++)
                if (i != q.server && is_eligible(i)) cands = {cands, i};
            order_by_load(cands, 1'b1);
            cands = {cands, int'(q.server)};
            pos = 0;
            for (int i = 0; i + 1 < cnt; i++) begin
                id = cands[pos];
                present_tbl[id] = 1'b1;
                disk_tbl[id] = disk_tbl[id] + 64'(q.block_size);
                expect_word(mk(id[3:0], llsp_pkg::ST_PLACE, i + 2 == cnt));
                pos = (pos + 1 == cands.size()) ? 0 : pos + 1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        llsp_pkg::t_res want;
        if (!i_rst_n) begin
            thresh <= llsp_pkg::MIN_FREE_RESET;
            for (int i = 0; i < NSRV; i++) begin
                on_tbl[i] = 1'b0;
                cap_tbl[i] = '0;
                present_tbl[i] = 1'b0;
                prim_tbl[i] = '0;
                disk_tbl[i] = '0;
            end
            placements_due.delete();
            fails = 0;
            due = 0;
        end else begin
            if (i_cfg_we) thresh <= i_cfg_data;
            if (i_req.valid && i_req.ready) predict_placement(i_req.data);
            if (o_res.valid && o_res.ready) begin
                if (placements_due.size() == 0) begin
                    $display("%0t: unexpected word %p", $time, o_res.data);
                    fails++;
                end else begin
                    want = placements_due.pop_front();
                    if (o_res.data.chosen_server !== want.chosen_server
                        || o_res.data.status !== want.status
                        || o_res.data.last !== want.last) begin
                        $display("%0t: expected %p, got %p", $time, want, o_res.data);
                        fails++;
                    end
                end
            end
            due = placements_due.size();
        end
    end
endmodule

// File: dv/tb_least_loaded_server_placement.sv
`timescale 1ns / 1ps
// Testbench top: drives requests and threshold writes, gives the verdict.
// Depends on llsp_pkg, llsp_if, llsp_checker and the placement block.
module tb_least_loaded_server_placement;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    logic        long_hold = 1'b0;

    llsp_req_if req_ch ();
    llsp_res_if res_ch ();

    always #2 i_clk = ~i_clk;

    least_loaded_server_placement i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_req(req_ch), .o_res(res_ch)
    );

    llsp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_req(req_ch), .o_res(res_ch), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        res_ch.ready = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int g;
        bit held;
        held = 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold && !held) begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end
            g = gap_len();
            if (g > 0) begin
                res_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // valid stays up after accept; a later send with a gap, drain_then_write or the end of the test drops it
    task automatic send(llsp_pkg::t_req q);
        int g;
        g = gap_len();
        if (g > 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= q;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    function automatic llsp_pkg::t_req mk_req(logic [1:0] op, logic [3:0] s, logic onl,
                                              logic [31:0] cap, logic [5:0] cnt,
                                              logic [31:0] bsz);
        llsp_pkg::t_req q;
        q.op = op;
        q.server = s;
        q.online = onl;
        q.capacity_mb = cap;
        q.request_count = cnt;
        q.block_size = bsz;
        return q;
    endfunction

    function automatic logic [31:0] rand_cap();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 200);
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic llsp_pkg::t_req rand_req();
        llsp_pkg::t_req q;
        int r;
        q = mk_req(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)), rand_cap(), 6'($urandom_range(0, 8)),
                   $urandom());
        r = $urandom_range(0, 9);
        if (r == 0) q.request_count = 6'($urandom_range(0, 63));
        else if (r == 1) q.request_count = 6'($urandom_range(20, 33));
        if ($urandom_range(0, 3) == 0) q.block_size = 32'hFFFF_FFFF - $urandom_range(0, 3);
        return q;
    endfunction

    task automatic drain_then_write(logic [31:0] v);
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [31:0] thresholds [4];
        int wait_cycles;
        thresholds = '{32'd0, 32'hFFFF_FFFF, 32'd150, 32'h8000_0000};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, bad counts, extremes
        send(mk_req(llsp_pkg::OP_PRIM, 4'd0, 1'b0, '0, 6'd1, '0));
        send(mk_req(llsp_pkg::OP_SEC, 4'd15, 1'b0, '0, 6'd3, 32'd5));
        send(mk_req(llsp_pkg::OP_PRIM, 4'd3, 1'b0, '0, 6'd0, '0));
        send(mk_req(llsp_pkg::OP_SEC, 4'd3, 1'b0, '0, 6'd0, '0));
        send(mk_req(llsp_pkg::OP_SEC, 4'd2, 1'b0, '0, 6'd1, 32'd7));
        for (int i = 0; i < 16; i += 3)
            send(mk_req(llsp_pkg::OP_UPDATE, 4'(i), 1'b1,
                        (i == 0) ? 32'hFFFF_FFFF : 32'd101, '0, '0));
        send(mk_req(llsp_pkg::OP_UPDATE, 4'd4, 1'b1, 32'd100, '0, '0));
        send(mk_req(llsp_pkg::OP_ADD, 4'd5, 1'b0, '0, '0, '0));
        send(mk_req(llsp_pkg::OP_ADD, 4'd0, 1'b1, '1, '1, '1));
        send(mk_req(llsp_pkg::OP_PRIM, 4'd0, 1'b0, '0, 6'd63, '0));
        send(mk_req(llsp_pkg::OP_SEC, 4'd3, 1'b0, '0, 6'd32, 32'hFFFF_FFFF));
        send(mk_req(llsp_pkg::OP_SEC, 4'd7, 1'b0, '0, 6'd33, 32'hFFFF_FFFF));
        send(mk_req(llsp_pkg::OP_ADD, 4'd3, 1'b0, '0, '0, '0));
        send(mk_req(llsp_pkg::OP_PRIM, 4'd0, 1'b0, '0, 6'd5, '0));

        // long receiver hold-off while requests keep coming
        long_hold <= 1'b1;
        for (int i = 0; i < 10; i++) send(rand_req());

        for (int phase = 0; phase < 5; phase++) begin
            if (phase > 0) drain_then_write(thresholds[phase - 1]);
            for (int i = 0; i < 78; i++) send(rand_req());
        end

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_least_loaded_server_placement OK");
        else
            $display("tb_least_loaded_server_placement NOT OK");
        $finish;
    end

    initial begin
        #40000000;
        $display("tb_least_loaded_server_placement NOT OK");
        $finish;
    end
endmodule
